// File: sv/lru_frame_replacer_top_macros.svh
// ============================================================================
// LRU frame replacer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is asserted.
// ============================================================================
`ifndef LRU_FRAME_REPLACER_TOP_MACROS_SVH
`define LRU_FRAME_REPLACER_TOP_MACROS_SVH

// Property holds in the same cycle.
`define LFR_ASSERT_NOW(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lfr_pkg.sv
// ============================================================================
// LRU frame replacer package
// Constants, operation codes, controller states and payload types.
// ============================================================================
package lfr_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);

    localparam logic [COUNT_W-1:0] FRAMES_RESET = COUNT_W'(MAX_FRAMES);

    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_PIN    = 2'd1,
        OP_UNPIN  = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FRAME_W-1:0] frame_index;
    } t_in_item;

    typedef struct packed {
        logic               victim_found;
        logic [FRAME_W-1:0] victim_frame;
        logic [COUNT_W-1:0] evictable_count;
    } t_out_item;

endpackage

// File: sv/lfr_link_ram.sv
// ============================================================================
// LRU frame replacer link memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module lfr_link_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/lru_frame_replacer_top.sv
// ============================================================================
// LRU frame replacer top level
// The request and the link memory read of the addressed frame are
// registered on transfer; the update step then writes the links of its
// neighbors and registers the result. No new operation is taken during it.
// Reset: synchronous, active low; the list is empty and frames_in_use is 64.
// ============================================================================
`include "lru_frame_replacer_top_macros.svh"

module lru_frame_replacer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lfr_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lfr_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lfr_pkg::COUNT_W-1:0]   i_cfg_data
);

    lfr_pkg::t_state                  r_state, n_state;
    logic [lfr_pkg::COUNT_W-1:0]      r_frames_in_use;
    logic [lfr_pkg::MAX_FRAMES-1:0]   r_in_list, n_in_list;
    logic [lfr_pkg::FRAME_W-1:0]      r_head, n_head;
    logic [lfr_pkg::FRAME_W-1:0]      r_tail, n_tail;
    logic [lfr_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [1:0]                       r_op;
    logic [lfr_pkg::FRAME_W-1:0]      r_frame;
    logic                             r_ok;
    logic                             r_out_valid;
    lfr_pkg::t_out_item               r_out, n_out;

    logic                             w_in_accept;
    logic                             w_update;
    logic [lfr_pkg::FRAME_W-1:0]      w_rd_addr;
    logic [lfr_pkg::FRAME_W-1:0]      w_prev, w_next;
    logic                             w_do_unlink, w_do_append;
    logic                             w_prev_we, w_next_we;
    logic [lfr_pkg::FRAME_W-1:0]      w_prev_waddr, w_prev_wdata;
    logic [lfr_pkg::FRAME_W-1:0]      w_next_waddr, w_next_wdata;

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfr_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = lfr_pkg::ST_UPDATE;
                end
            end
            lfr_pkg::ST_UPDATE: begin
                n_state = lfr_pkg::ST_IDLE;
            end
            default: begin
                n_state = lfr_pkg::ST_IDLE;
            end
        endcase
    end

    // A transfer is taken only when the output register will be free by the
    // time the update finishes.
    always_comb begin
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        w_update    = 1'b0;
        case (r_state)
            lfr_pkg::ST_IDLE: begin
                o_in_stall  = r_out_valid && i_out_stall;
                o_cfg_ready = 1'b1;
            end
            lfr_pkg::ST_UPDATE: begin
                w_update = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lfr_pkg::FRAMES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Request capture and node read
    // ------------------------------------------------------------------
    // A victim operation works on the current head of the list.
    assign w_rd_addr = (i_in_item.operation == lfr_pkg::OP_VICTIM) ? r_head
                                                                   : i_in_item.frame_index;

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op    <= i_in_item.operation;
            r_frame <= w_rd_addr;
            r_ok    <= {1'b0, i_in_item.frame_index} < r_frames_in_use;
        end
    end

    lfr_link_ram #(
        .DEPTH (lfr_pkg::MAX_FRAMES),
        .WIDTH (lfr_pkg::FRAME_W)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_prev_we),
        .i_wr_addr (w_prev_waddr),
        .i_wr_data (w_prev_wdata),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_prev)
    );

    lfr_link_ram #(
        .DEPTH (lfr_pkg::MAX_FRAMES),
        .WIDTH (lfr_pkg::FRAME_W)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_next_we),
        .i_wr_addr (w_next_waddr),
        .i_wr_data (w_next_wdata),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_next)
    );

    // ------------------------------------------------------------------
    // List update: at most one write to each link memory per operation
    // ------------------------------------------------------------------
    always_comb begin
        w_do_unlink  = ((r_op == lfr_pkg::OP_VICTIM) && (r_count != '0)) ||
                       ((r_op == lfr_pkg::OP_PIN) && r_ok && r_in_list[r_frame]);
        w_do_append  = (r_op == lfr_pkg::OP_UNPIN) && r_ok && !r_in_list[r_frame];

        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_in_list    = r_in_list;
        w_prev_we    = 1'b0;
        w_prev_waddr = w_next;
        w_prev_wdata = w_prev;
        w_next_we    = 1'b0;
        w_next_waddr = w_prev;
        w_next_wdata = w_next;

        if (w_do_unlink) begin
            if (r_frame == r_head) begin
                n_head = w_next;
            end else begin
                w_next_we = 1'b1;
            end
            if (r_frame == r_tail) begin
                n_tail = w_prev;
            end else begin
                w_prev_we = 1'b1;
            end
            n_in_list[r_frame] = 1'b0;
            n_count            = r_count - lfr_pkg::COUNT_W'(1);
            if (n_count == '0) begin
                n_head = '0;
                n_tail = '0;
            end
        end else if (w_do_append) begin
            // The next link of the tail is never read, so it is left alone.
            w_prev_we    = 1'b1;
            w_prev_waddr = r_frame;
            w_prev_wdata = r_tail;
            if (r_count == '0) begin
                n_head = r_frame;
            end else begin
                w_next_we    = 1'b1;
                w_next_waddr = r_tail;
                w_next_wdata = r_frame;
            end
            n_tail             = r_frame;
            n_in_list[r_frame] = 1'b1;
            n_count            = r_count + lfr_pkg::COUNT_W'(1);
        end

        if (!w_update) begin
            w_prev_we = 1'b0;
            w_next_we = 1'b0;
        end

        n_out.victim_found    = (r_op == lfr_pkg::OP_VICTIM) && (r_count != '0);
        n_out.victim_frame    = n_out.victim_found ? r_frame : '0;
        n_out.evictable_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_list <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else if (w_update) begin
            r_in_list <= n_in_list;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LFR_ASSERT_NOW(a_count_matches_flags, i_clk, i_rst_n,
                    r_count == $countones(r_in_list),
                    "evictable count disagrees with list flags")
    `LFR_ASSERT_NOW(a_ends_in_list, i_clk, i_rst_n,
                    (r_count == '0) || (r_in_list[r_head] && r_in_list[r_tail]),
                    "head or tail frame is not in the list")
    `LFR_ASSERT_NOW(a_out_free_on_update, i_clk, i_rst_n,
                    !w_update || !r_out_valid,
                    "update would overwrite a pending result")
    `LFR_ASSERT_NEXT(a_accept_updates, i_clk, i_rst_n, w_in_accept, w_update,
                     "accepted operation did not reach the update step")

endmodule

// File: tb/lru_order_checker.sv
// ============================================================================
// LRU frame replacer checker
// Watches the operation, result and register channels of the replacer. It
// keeps its own evictable list (a doubly linked list over the frames) and
// the managed frame count, predicts the reply of every accepted operation,
// and compares each accepted result field by field with the oldest reply
// still owed.
// ============================================================================
`timescale 1ns / 1ps

module lru_order_checker
    import lfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [FRAME_W-1:0] link_prev [MAX_FRAMES];
    logic [FRAME_W-1:0] link_next [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] evictable;
    logic [FRAME_W-1:0] oldest;
    logic [FRAME_W-1:0] newest;
    logic [COUNT_W-1:0] evict_count;
    logic [COUNT_W-1:0] frame_limit;

    t_out_item queued_replies [$];
    int        mismatches;

    function automatic logic is_managed(input logic [FRAME_W-1:0] f);
        return {1'b0, f} < frame_limit;
    endfunction

    function automatic void drop_frame(input logic [FRAME_W-1:0] f);
        logic [FRAME_W-1:0] p;
        logic [FRAME_W-1:0] n;
        if (!evictable[f]) return;
        p = link_prev[f];
        n = link_next[f];
        if (f == oldest) begin
            oldest = n;
        end else begin
            link_next[p] = n;
        end
        if (f == newest) begin
            newest = p;
        end else begin
            link_prev[n] = p;
        end
        evictable[f] = 1'b0;
        if (evict_count != 0) evict_count = evict_count - 1'b1;
        if (evict_count == 0) begin
            oldest = '0;
            newest = '0;
        end
    endfunction

    // An unpin of a frame that is already evictable leaves its age alone.
    function automatic void add_frame(input logic [FRAME_W-1:0] f);
        if (evictable[f]) return;
        link_prev[f] = newest;
        link_next[f] = '0;
        evictable[f] = 1'b1;
        if (evict_count == 0) begin
            oldest = f;
        end else begin
            link_next[newest] = f;
        end
        newest = f;
        evict_count = evict_count + 1'b1;
    endfunction

    function automatic t_out_item lru_apply_op(input t_in_item item);
        t_out_item reply;
        reply = '0;
        case (item.operation)
            OP_VICTIM: begin
                if (evict_count != 0) begin
                    reply.victim_found = 1'b1;
                    reply.victim_frame = oldest;
                    drop_frame(oldest);
                end
            end
            OP_PIN: begin
                if (is_managed(item.frame_index)) drop_frame(item.frame_index);
            end
            OP_UNPIN: begin
                if (is_managed(item.frame_index)) add_frame(item.frame_index);
            end
            default: ;
        endcase
        reply.evictable_count = evict_count;
        return reply;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                link_prev[i] = '0;
                link_next[i] = '0;
            end
            evictable   = '0;
            oldest      = '0;
            newest      = '0;
            evict_count = '0;
            frame_limit = FRAMES_RESET;
            queued_replies.delete();
            mismatches  = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (queued_replies.size() == 0) begin
                    $error("result transfer with no operation outstanding: %p", i_out_item);
                    mismatches++;
                end else begin
                    want = queued_replies.pop_front();
                    check_field("victim_found", want.victim_found, i_out_item.victim_found);
                    check_field("victim_frame", want.victim_frame, i_out_item.victim_frame);
                    check_field("evictable_count", want.evictable_count,
                                i_out_item.evictable_count);
                end
            end
            if (i_cfg_valid && i_cfg_ready) frame_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall) queued_replies.push_back(lru_apply_op(i_in_item));
        end
        o_fail_count <= mismatches;
        o_pending    <= queued_replies.size();
    end

endmodule

// File: tb/tb.sv
// ============================================================================
// LRU frame replacer testbench
// Drives victim, pin and unpin operations into the replacer under several
// managed frame counts and idling patterns, including one long receiver
// hold-off that backs the block up. The checker beside the block predicts
// and compares every result; this module gives the verdict.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import lfr_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 75;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data = '0;

    int fail_count;
    int pending;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_armed = 1'b0;
    bit hold_served = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic [COUNT_W-1:0] frame_limit = FRAMES_RESET;

    initial begin
        forever #5 clk = ~clk;
    end

    lru_frame_replacer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    lru_order_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side. The one long hold-off is counted here so that the sender
    // keeps offering operations and the block backs up.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_served) begin
            hold_served <= 1'b1;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid is left high after a transfer; the next call either idles or
    // presents the next operation, so valid is never dropped and raised in
    // the same step.
    task automatic send_op(input logic [1:0] op, input logic [FRAME_W-1:0] frame);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{operation: op, frame_index: frame};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_limit(input logic [COUNT_W-1:0] value);
        drain();
        cfg_valid   <= 1'b1;
        cfg_data    <= value;
        frame_limit = value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int unpin_pct);
        int pick;
        int span;
        logic [1:0] op;
        logic [FRAME_W-1:0] frame;
        pick = $urandom_range(99);
        if (pick < 4) begin
            op = OP_RESERVED;
        end else if (pick < 4 + unpin_pct) begin
            op = OP_UNPIN;
        end else if (pick < 4 + unpin_pct + (96 - unpin_pct) / 2) begin
            op = OP_PIN;
        end else begin
            op = OP_VICTIM;
        end
        span = (frame_limit == 0 || frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
        // Mostly managed frames, with some ids above the managed count.
        if ($urandom_range(9) == 0) begin
            frame = FRAME_W'($urandom_range(MAX_FRAMES - 1));
        end else begin
            frame = FRAME_W'($urandom_range(span - 1));
        end
        send_op(op, frame);
    endtask

    initial begin
        logic [COUNT_W-1:0] limits [6];
        int tx_modes [4];
        int rx_modes [4];
        limits   = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd0, 7'd0};
        tx_modes = '{0, 87, 0, 35};
        rx_modes = '{0, 0, 87, 35};
        limits[5] = COUNT_W'($urandom_range(MAX_FRAMES - 1, 2));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset frame count.
        send_op(OP_VICTIM, 6'd63);
        send_op(OP_PIN, 6'd0);
        send_op(OP_UNPIN, 6'd0);
        send_op(OP_UNPIN, 6'd63);
        send_op(OP_UNPIN, 6'd0);
        send_op(OP_UNPIN, 6'd31);
        send_op(OP_PIN, 6'd63);
        send_op(OP_RESERVED, 6'd42);
        send_op(OP_VICTIM, 6'd21);
        send_op(OP_VICTIM, 6'd0);
        send_op(OP_VICTIM, 6'd0);
        send_op(OP_UNPIN, 6'd10);
        send_op(OP_UNPIN, 6'd20);
        send_op(OP_UNPIN, 6'd30);
        // Frames above a lowered count stay evictable but cannot be pinned.
        set_frame_limit(7'd16);
        send_op(OP_PIN, 6'd20);
        send_op(OP_UNPIN, 6'd40);
        send_op(OP_VICTIM, 6'd0);
        send_op(OP_PIN, 6'd30);
        send_op(OP_VICTIM, 6'd0);
        send_op(OP_VICTIM, 6'd0);
        set_frame_limit(7'd0);
        send_op(OP_UNPIN, 6'd0);
        send_op(OP_PIN, 6'd0);
        set_frame_limit(7'd127);
        send_op(OP_UNPIN, 6'd63);
        send_op(OP_PIN, 6'd63);

        foreach (limits[s]) begin
            set_frame_limit(limits[s]);
            for (int m = 0; m < 4; m++) begin
                int unpin_pct;
                tx_idle_pct  = tx_modes[m];
                rx_stall_pct = rx_modes[m];
                unpin_pct    = $urandom_range(70, 30);
                if (s == 0 && m == 0) hold_armed = 1'b1;
                repeat (PHASE_ITEMS) send_random(unpin_pct);
            end
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
